[design/mm_pkg.sv]
// Shared types, codes and helpers for the matrix multiply block.
package mm_pkg;

    // Default sizes
    localparam int MAX_DIM_DEF       = 8;
    localparam int ELEMENT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int COORD_LIMIT = 8;
    localparam int COORD_W     = 3;
    localparam int DIM_REG_W   = 4;
    localparam int IN_VALUE_W  = 16;
    localparam int PRODUCT_W   = 35;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    // Item kinds
    localparam logic [1:0] KIND_WRITE_A = 2'd0;
    localparam logic [1:0] KIND_WRITE_B = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_DRAIN,
        S_MISMATCH
    } t_state;

    // Token that walks down the cell chain with one element of A
    typedef struct packed {
        logic   valid;
        logic   first;
        logic   last;
        t_coord k;
    } t_token;

    // Result capture and unload control for the chain
    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctl;

    // Write of one element of B
    typedef struct packed {
        logic   en;
        t_coord row;
        t_coord col;
    } t_bwr;

    // Number of cells, capped by the coordinate range
    function automatic int dim_use(int max_dim);
        return (max_dim < COORD_LIMIT) ? max_dim : COORD_LIMIT;
    endfunction

    // Highest index in use for a dimension register, with the dimension saturated to 1 .. lim
    function automatic t_coord eff_last(logic [DIM_REG_W-1:0] r, int lim);
        t_coord v;
        if (r == '0) begin
            v = '0;
        end else if (int'(r) > lim) begin
            v = t_coord'(lim - 1);
        end else begin
            v = t_coord'(r - 4'd1);
        end
        return v;
    endfunction

endpackage

[design/mm_in_if.sv]
// Input channel: one write or compute word.
interface mm_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              kind;
    mm_pkg::t_coord                          row_index;
    mm_pkg::t_coord                          col_index;
    logic signed [mm_pkg::IN_VALUE_W-1:0]    element_value;

    modport source (
        output valid, kind, row_index, col_index, element_value,
        input  ready
    );
    modport sink (
        input  valid, kind, row_index, col_index, element_value,
        output ready
    );
endinterface

[design/mm_out_if.sv]
// Output channel: one product element word.
interface mm_out_if;
    logic                                  valid;
    logic                                  ready;
    mm_pkg::t_coord                        out_row;
    mm_pkg::t_coord                        out_col;
    logic signed [mm_pkg::PRODUCT_W-1:0]   product_value;
    logic                                  size_mismatch;
    logic                                  last_result;

    modport source (
        output valid, out_row, out_col, product_value, size_mismatch, last_result,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_col, product_value, size_mismatch, last_result,
        output ready
    );
endinterface

[design/mm_cell.sv]
// One cell of the chain: owns a column of B and accumulates one element of C.
module mm_cell #(
    parameter int EW    = mm_pkg::ELEMENT_WIDTH_DEF,
    parameter int DEPTH = mm_pkg::MAX_DIM_DEF,
    parameter int COL   = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mm_pkg::t_token              i_tok,
    input  logic signed [EW-1:0]        i_a,
    output mm_pkg::t_token              o_tok,
    output logic signed [EW-1:0]        o_a,
    input  mm_pkg::t_chain_ctl          i_ctl,
    input  mm_pkg::t_bwr                i_bwr,
    input  logic signed [EW-1:0]        i_bdata,
    input  logic signed [2*EW+2:0]      i_sh,
    output logic signed [2*EW+2:0]      o_sh
);
    localparam int KW   = $clog2(DEPTH);
    localparam int PW   = 2 * EW;
    localparam int ACCW = 2 * EW + 3;

    logic signed [EW-1:0]   r_bmem [DEPTH];
    mm_pkg::t_token         r_tok;
    logic signed [EW-1:0]   r_a;
    logic signed [EW-1:0]   r_b;
    logic                   r_p_v;
    logic                   r_p_first;
    logic signed [PW-1:0]   r_p;
    logic signed [ACCW-1:0] r_acc;
    logic signed [ACCW-1:0] r_sh;

    // Column store of B: write on a matching column, registered read at k
    always_ff @(posedge i_clk) begin
        if (i_bwr.en && i_bwr.col == mm_pkg::t_coord'(COL)) begin
            r_bmem[i_bwr.row[KW-1:0]] <= i_bdata;
        end
        r_b <= r_bmem[i_tok.k[KW-1:0]];
    end

    // Stage one: hold the token and the A element, pass both on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
        end
        r_a <= i_a;
    end

    // Stage two: multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= r_tok.valid;
        end
        r_p_first <= r_tok.first;
        r_p       <= PW'(r_a) * PW'(r_b);
    end

    // Stage three: accumulate, restart on the first term
    always_ff @(posedge i_clk) begin
        if (r_p_v) begin
            r_acc <= r_p_first ? ACCW'(r_p) : r_acc + ACCW'(r_p);
        end
    end

    // Unload register: capture the sum, then shift towards cell zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_sh <= r_acc;
        end else if (i_ctl.shift) begin
            r_sh <= i_sh;
        end
    end

    assign o_tok = r_tok;
    assign o_a   = r_a;
    assign o_sh  = r_sh;

endmodule

[design/mm_seq.sv]
// Sequencer: configuration, store of A, row scheduling and result unload.
module mm_seq #(
    parameter int EW    = mm_pkg::ELEMENT_WIDTH_DEF,
    parameter int DEPTH = mm_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mm_pkg::DIM_REG_W-1:0]        i_cfg_data,
    mm_in_if.sink                               i_in,
    mm_out_if.source                            o_out,
    output mm_pkg::t_token                      o_tok,
    output logic signed [EW-1:0]                o_a,
    output mm_pkg::t_chain_ctl                  o_ctl,
    output mm_pkg::t_bwr                        o_bwr,
    output logic signed [EW-1:0]                o_bdata,
    input  mm_pkg::t_token                      i_tail,
    input  logic signed [2*EW+2:0]              i_sh0
);
    localparam int AW = $clog2(DEPTH * DEPTH);

    mm_pkg::t_state                 r_state, n_state;
    logic [mm_pkg::DIM_REG_W-1:0]   r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    mm_pkg::t_coord                 r_ra_last, n_ra_last;
    mm_pkg::t_coord                 r_ca_last, n_ca_last;
    mm_pkg::t_coord                 r_cb_last, n_cb_last;
    mm_pkg::t_coord                 r_i, n_i;
    mm_pkg::t_coord                 r_j, n_j;
    mm_pkg::t_coord                 r_k, n_k;
    mm_pkg::t_token                 r_tok, n_tok;
    logic                           r_tail_seen;
    logic                           r_tail_done;
    logic signed [EW-1:0]           r_amem [DEPTH * DEPTH];
    logic signed [EW-1:0]           r_a_q;

    logic                           w_in_acc;
    logic                           w_out_acc;
    logic                           w_in_range;
    logic                           w_a_we;
    logic signed [EW-1:0]           w_elem;
    logic [AW-1:0]                  w_wr_addr;
    logic [AW-1:0]                  w_rd_addr;
    mm_pkg::t_coord                 w_ca_eff, w_rb_eff;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = o_out.valid && o_out.ready;
    assign w_in_range = (int'(i_in.row_index) < DEPTH) && (int'(i_in.col_index) < DEPTH);
    assign w_elem     = EW'(32'(i_in.element_value));
    assign w_wr_addr  = AW'(int'(i_in.row_index) * DEPTH + int'(i_in.col_index));
    assign w_rd_addr  = AW'(int'(r_i) * DEPTH + int'(r_k));
    assign w_a_we     = w_in_acc && i_in.kind == mm_pkg::KIND_WRITE_A && w_in_range;
    assign w_ca_eff   = mm_pkg::eff_last(r_cols_a, DEPTH);
    assign w_rb_eff   = mm_pkg::eff_last(r_rows_b, DEPTH);

    // Dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= mm_pkg::DIM_RESET;
            r_cols_a <= mm_pkg::DIM_RESET;
            r_rows_b <= mm_pkg::DIM_RESET;
            r_cols_b <= mm_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mm_pkg::CFG_ROWS_A: r_rows_a <= i_cfg_data;
                mm_pkg::CFG_COLS_A: r_cols_a <= i_cfg_data;
                mm_pkg::CFG_ROWS_B: r_rows_b <= i_cfg_data;
                mm_pkg::CFG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Store of A: one write port, registered read for the feed
    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_amem[w_wr_addr] <= w_elem;
        end
        r_a_q <= r_amem[w_rd_addr];
    end

    // State and counters; the row ends once the last cell has folded in its final term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm_pkg::S_IDLE;
            r_tok       <= '0;
            r_tail_seen <= 1'b0;
            r_tail_done <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tok       <= n_tok;
            r_tail_seen <= i_tail.valid && i_tail.last;
            r_tail_done <= r_tail_seen;
        end
        r_ra_last <= n_ra_last;
        r_ca_last <= n_ca_last;
        r_cb_last <= n_cb_last;
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
    end

    // Next state, feed tokens and unload control
    always_comb begin
        n_state   = r_state;
        n_ra_last = r_ra_last;
        n_ca_last = r_ca_last;
        n_cb_last = r_cb_last;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_tok     = '0;
        o_ctl     = '0;
        unique case (r_state)
            mm_pkg::S_IDLE: begin
                if (w_in_acc && i_in.kind == mm_pkg::KIND_COMPUTE) begin
                    n_ra_last = mm_pkg::eff_last(r_rows_a, DEPTH);
                    n_ca_last = w_ca_eff;
                    n_cb_last = mm_pkg::eff_last(r_cols_b, DEPTH);
                    n_i       = '0;
                    n_k       = '0;
                    n_state   = (w_ca_eff != w_rb_eff) ? mm_pkg::S_MISMATCH : mm_pkg::S_FEED;
                end
            end
            mm_pkg::S_FEED: begin
                n_tok.valid = 1'b1;
                n_tok.first = (r_k == '0);
                n_tok.last  = (r_k == r_ca_last);
                n_tok.k     = r_k;
                if (r_k == r_ca_last) begin
                    n_state = mm_pkg::S_WAIT;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            mm_pkg::S_WAIT: begin
                if (r_tail_done) begin
                    o_ctl.load = 1'b1;
                    n_j        = '0;
                    n_state    = mm_pkg::S_DRAIN;
                end
            end
            mm_pkg::S_DRAIN: begin
                if (w_out_acc) begin
                    o_ctl.shift = 1'b1;
                    if (r_j == r_cb_last) begin
                        if (r_i == r_ra_last) begin
                            n_state = mm_pkg::S_IDLE;
                        end else begin
                            n_i     = r_i + 3'd1;
                            n_k     = '0;
                            n_state = mm_pkg::S_FEED;
                        end
                    end else begin
                        n_j = r_j + 3'd1;
                    end
                end
            end
            mm_pkg::S_MISMATCH: begin
                if (w_out_acc) begin
                    n_state = mm_pkg::S_IDLE;
                end
            end
            default: n_state = mm_pkg::S_IDLE;
        endcase
    end

    // Channel drive
    assign i_in.ready = (r_state == mm_pkg::S_IDLE);

    assign o_out.valid         = (r_state == mm_pkg::S_DRAIN) || (r_state == mm_pkg::S_MISMATCH);
    assign o_out.out_row       = (r_state == mm_pkg::S_DRAIN) ? r_i : '0;
    assign o_out.out_col       = (r_state == mm_pkg::S_DRAIN) ? r_j : '0;
    assign o_out.product_value = (r_state == mm_pkg::S_DRAIN) ?
                                 mm_pkg::PRODUCT_W'(i_sh0) : '0;
    assign o_out.size_mismatch = (r_state == mm_pkg::S_MISMATCH);
    assign o_out.last_result   = (r_state == mm_pkg::S_MISMATCH) ||
                                 (r_j == r_cb_last && r_i == r_ra_last);

    assign o_tok       = r_tok;
    assign o_a         = r_a_q;
    assign o_bwr.en    = w_in_acc && i_in.kind == mm_pkg::KIND_WRITE_B && w_in_range;
    assign o_bwr.row   = i_in.row_index;
    assign o_bwr.col   = i_in.col_index;
    assign o_bdata     = w_elem;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while a result is pending");

    a_tail_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_done |-> r_state == mm_pkg::S_WAIT)
        else $error("row finished outside the wait phase");

    a_tok_from_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok.valid |-> $past(r_state) == mm_pkg::S_FEED)
        else $error("token issued outside the feed phase");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_out.last_result) |=> r_state == mm_pkg::S_IDLE)
        else $error("compute did not end on its last result");
`endif

endmodule

[design/matrix_multiply_top.sv]
// Top level of the matrix multiply block: sequencer and chain of cells.
//
// Write words load one element of A or B, and the block stays ready for the
// next word after each. A compute word produces C = A * B row by row: the
// sequencer streams row i of A, one element per cycle, down a chain of
// N = min(MAX_DIM, 8) cells, each holding one column of B and one running
// sum. Each row of C is fed as cols_of_a elements, then waits for the token
// to reach the last cell and its sum to settle, then is unloaded as
// cols_of_b output words, which the sink can stall. A size mismatch gives one
// flagged word the cycle after the compute word. New input is taken only
// when no compute is in progress.
module matrix_multiply_top #(
    parameter int MAX_DIM       = mm_pkg::MAX_DIM_DEF,
    parameter int ELEMENT_WIDTH = mm_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mm_pkg::DIM_REG_W-1:0]    i_cfg_data,
    mm_in_if.sink                           i_in,
    mm_out_if.source                        o_out
);
    localparam int DEPTH = mm_pkg::dim_use(MAX_DIM);
    localparam int EW    = ELEMENT_WIDTH;
    localparam int ACCW  = 2 * EW + 3;

    mm_pkg::t_token             w_tok [DEPTH+1];
    logic signed [EW-1:0]       w_a   [DEPTH];
    logic signed [ACCW-1:0]     w_sh  [DEPTH+1];
    mm_pkg::t_chain_ctl         w_ctl;
    mm_pkg::t_bwr               w_bwr;
    logic signed [EW-1:0]       w_bdata;

    // Nothing shifts in behind the last cell
    assign w_sh[DEPTH] = '0;

    mm_seq #(
        .EW    (EW),
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_tok      (w_tok[0]),
        .o_a        (w_a[0]),
        .o_ctl      (w_ctl),
        .o_bwr      (w_bwr),
        .o_bdata    (w_bdata),
        .i_tail     (w_tok[DEPTH]),
        .i_sh0      (w_sh[0])
    );

    // Chain of cells, one per column of C
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        if (j == DEPTH - 1) begin : g_end
            mm_cell #(
                .EW    (EW),
                .DEPTH (DEPTH),
                .COL   (j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[j]),
                .i_a     (w_a[j]),
                .o_tok   (w_tok[j+1]),
                .o_a     (),
                .i_ctl   (w_ctl),
                .i_bwr   (w_bwr),
                .i_bdata (w_bdata),
                .i_sh    (w_sh[j+1]),
                .o_sh    (w_sh[j])
            );
        end else begin : g_mid
            mm_cell #(
                .EW    (EW),
                .DEPTH (DEPTH),
                .COL   (j)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[j]),
                .i_a     (w_a[j]),
                .o_tok   (w_tok[j+1]),
                .o_a     (w_a[j+1]),
                .i_ctl   (w_ctl),
                .i_bwr   (w_bwr),
                .i_bdata (w_bdata),
                .i_sh    (w_sh[j+1]),
                .o_sh    (w_sh[j])
            );
        end
    end

endmodule

[bench/tb_matrix_multiply_top.sv]
// Self-checking testbench for the matrix multiply top level with random flow control.
`timescale 1ns / 1ps

module tb_matrix_multiply_top;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int TIMEOUT_NS    = 2000000;
    localparam int PRINT_LIMIT   = 40;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [1:0]                            kind;
        mm_pkg::t_coord                        row_index;
        mm_pkg::t_coord                        col_index;
        logic signed [mm_pkg::IN_VALUE_W-1:0]  element_value;
    } t_load_word;

    typedef struct {
        mm_pkg::t_coord                  row;
        mm_pkg::t_coord                  col;
        logic [mm_pkg::PRODUCT_W-1:0]    value;
        logic                            mismatch;
        logic                            last;
    } t_c_element;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [mm_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [mm_pkg::DIM_REG_W-1:0]  cfg_data;

    mm_in_if  in_ch ();
    mm_out_if out_ch ();

    matrix_multiply_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Shadow stores and dimension registers of the block
    logic signed [mm_pkg::IN_VALUE_W-1:0] a_elems [64];
    logic signed [mm_pkg::IN_VALUE_W-1:0] b_elems [64];
    logic [mm_pkg::DIM_REG_W-1:0]         dim_rows_a, dim_cols_a, dim_rows_b, dim_cols_b;

    // Entries loaded so far, tracked as words are queued
    bit [63:0]    a_loaded;
    bit [63:0]    b_loaded;

    t_load_word   pending_words [$];
    t_c_element   expected_products [$];
    t_idle_mode   idle_mode = IDLE_NONE;
    int unsigned  queued_count = 0;
    int unsigned  error_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Saturate a dimension register to 1 .. 8
    function automatic int unsigned span_of(input logic [mm_pkg::DIM_REG_W-1:0] r);
        if (r == '0) return 1;
        if (r > 4'd8) return 8;
        return int'(r);
    endfunction

    function automatic logic signed [mm_pkg::IN_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return mm_pkg::IN_VALUE_W'($urandom);
        endcase
    endfunction

    function automatic bit sender_gap();
        if (idle_mode == IDLE_SEND) return $urandom_range(0, 99) < 58;
        if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 25;
        return 1'b0;
    endfunction

    function automatic bit receiver_stall();
        if (idle_mode == IDLE_RECV) return $urandom_range(0, 99) < 58;
        if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 25;
        return 1'b0;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Update the shadow stores, or work out every element of C (or the flagged mismatch word) for a compute word
    task automatic predict_word(input logic [1:0] kind, input mm_pkg::t_coord row,
                                input mm_pkg::t_coord col,
                                input logic signed [mm_pkg::IN_VALUE_W-1:0] val);
        int unsigned       ra, ca, rb, cb;
        logic signed [63:0] acc, av, bv;
        t_c_element        e;
        case (kind)
            mm_pkg::KIND_WRITE_A: a_elems[{row, col}] = val;
            mm_pkg::KIND_WRITE_B: b_elems[{row, col}] = val;
            mm_pkg::KIND_COMPUTE: begin
                ra = span_of(dim_rows_a);
                ca = span_of(dim_cols_a);
                rb = span_of(dim_rows_b);
                cb = span_of(dim_cols_b);
                if (ca != rb) begin
                    e.row = '0;
                    e.col = '0;
                    e.value = '0;
                    e.mismatch = 1'b1;
                    e.last = 1'b1;
                    expected_products.insert(expected_products.size(), e);
                end else begin
                    for (int i = 0; i < ra; i++) begin
                        for (int j = 0; j < cb; j++) begin
                            acc = '0;
                            for (int k = 0; k < ca; k++) begin
                                av = a_elems[i * 8 + k];
                                bv = b_elems[k * 8 + j];
                                acc += av * bv;
                            end
                            e.row = mm_pkg::t_coord'(i);
                            e.col = mm_pkg::t_coord'(j);
                            e.value = acc[mm_pkg::PRODUCT_W-1:0];
                            e.mismatch = 1'b0;
                            e.last = (i == ra - 1) && (j == cb - 1);
                            expected_products.insert(expected_products.size(), e);
                        end
                    end
                end
            end
            default: ;  // unused kind: dropped by the block
        endcase
    endtask

    // Driver: predict on acceptance, then present the next pending word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid         <= 1'b0;
            in_ch.kind          <= mm_pkg::KIND_WRITE_A;
            in_ch.row_index     <= '0;
            in_ch.col_index     <= '0;
            in_ch.element_value <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(in_ch.kind, in_ch.row_index, in_ch.col_index, in_ch.element_value);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_words.size() != 0 && !sender_gap()) begin
                    in_ch.valid         <= 1'b1;
                    in_ch.kind          <= pending_words[0].kind;
                    in_ch.row_index     <= pending_words[0].row_index;
                    in_ch.col_index     <= pending_words[0].col_index;
                    in_ch.element_value <= pending_words[0].element_value;
                    void'(pending_words.pop_front());
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_product();
        t_c_element e;
        if (expected_products.size() == 0) begin
            report_error($sformatf("unexpected word row %0d col %0d value %0d",
                                   out_ch.out_row, out_ch.out_col, out_ch.product_value));
        end else begin
            e = expected_products.pop_front();
            if (out_ch.out_row !== e.row)
                report_error($sformatf("out_row %0d, want %0d", out_ch.out_row, e.row));
            if (out_ch.out_col !== e.col)
                report_error($sformatf("out_col %0d, want %0d", out_ch.out_col, e.col));
            if (out_ch.product_value !== e.value)
                report_error($sformatf("C[%0d][%0d] = %0d, want %0d", e.row, e.col,
                                       out_ch.product_value, $signed(e.value)));
            if (out_ch.size_mismatch !== e.mismatch)
                report_error($sformatf("size_mismatch %b, want %b",
                                       out_ch.size_mismatch, e.mismatch));
            if (out_ch.last_result !== e.last)
                report_error($sformatf("last_result %b, want %b at C[%0d][%0d]",
                                       out_ch.last_result, e.last, e.row, e.col));
        end
    endtask

    // Monitor: check each accepted word, then choose whether to stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) check_product();
            out_ch.ready <= !receiver_stall();
        end
    end

    task automatic write_reg(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mm_pkg::DIM_REG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    task automatic set_dims(input logic [mm_pkg::DIM_REG_W-1:0] ra,
                            input logic [mm_pkg::DIM_REG_W-1:0] ca,
                            input logic [mm_pkg::DIM_REG_W-1:0] rb,
                            input logic [mm_pkg::DIM_REG_W-1:0] cb);
        write_reg(mm_pkg::CFG_ROWS_A, ra);
        write_reg(mm_pkg::CFG_COLS_A, ca);
        write_reg(mm_pkg::CFG_ROWS_B, rb);
        write_reg(mm_pkg::CFG_COLS_B, cb);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        dim_rows_a = ra;
        dim_cols_a = ca;
        dim_rows_b = rb;
        dim_cols_b = cb;
    endtask

    task automatic queue_word(input logic [1:0] kind, input mm_pkg::t_coord row,
                              input mm_pkg::t_coord col,
                              input logic signed [mm_pkg::IN_VALUE_W-1:0] val);
        t_load_word w;
        w.kind = kind;
        w.row_index = row;
        w.col_index = col;
        w.element_value = val;
        pending_words.insert(pending_words.size(), w);
        if (kind == mm_pkg::KIND_WRITE_A) a_loaded[{row, col}] = 1'b1;
        else if (kind == mm_pkg::KIND_WRITE_B) b_loaded[{row, col}] = 1'b1;
        if (kind != KIND_UNUSED) queued_count++;
    endtask

    // Write one element, mostly inside the region the product reads
    task automatic load_random(input logic [1:0] kind);
        int unsigned    nr, nc;
        mm_pkg::t_coord r, c;
        nr = span_of(kind == mm_pkg::KIND_WRITE_A ? dim_rows_a : dim_rows_b);
        nc = span_of(kind == mm_pkg::KIND_WRITE_A ? dim_cols_a : dim_cols_b);
        if ($urandom_range(0, 4) == 0) begin
            r = mm_pkg::t_coord'($urandom_range(0, 7));
            c = mm_pkg::t_coord'($urandom_range(0, 7));
        end else begin
            r = mm_pkg::t_coord'($urandom_range(0, nr - 1));
            c = mm_pkg::t_coord'($urandom_range(0, nc - 1));
        end
        queue_word(kind, r, c, pick_value());
    endtask

    // Load any entry the product would read that has never been written, then compute
    task automatic queue_compute();
        int unsigned ra, ca, rb, cb;
        ra = span_of(dim_rows_a);
        ca = span_of(dim_cols_a);
        rb = span_of(dim_rows_b);
        cb = span_of(dim_cols_b);
        if (ca == rb) begin
            for (int i = 0; i < ra; i++)
                for (int k = 0; k < ca; k++)
                    if (!a_loaded[i * 8 + k])
                        queue_word(mm_pkg::KIND_WRITE_A, mm_pkg::t_coord'(i),
                                   mm_pkg::t_coord'(k), pick_value());
            for (int k = 0; k < rb; k++)
                for (int j = 0; j < cb; j++)
                    if (!b_loaded[k * 8 + j])
                        queue_word(mm_pkg::KIND_WRITE_B, mm_pkg::t_coord'(k),
                                   mm_pkg::t_coord'(j), pick_value());
        end
        queue_word(mm_pkg::KIND_COMPUTE, mm_pkg::t_coord'($urandom),
                   mm_pkg::t_coord'($urandom), pick_value());
    endtask

    // Hold until every word is taken and every element of C has arrived
    task automatic drain();
        while (pending_words.size() != 0 || in_ch.valid || expected_products.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input logic [mm_pkg::DIM_REG_W-1:0] ra,
                              input logic [mm_pkg::DIM_REG_W-1:0] ca,
                              input logic [mm_pkg::DIM_REG_W-1:0] rb,
                              input logic [mm_pkg::DIM_REG_W-1:0] cb,
                              input t_idle_mode mode, input int unsigned n);
        int unsigned target;
        set_dims(ra, ca, rb, cb);
        idle_mode = mode;
        target = queued_count + n;
        while (queued_count < target) begin
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 15) == 0)
                    queue_word(KIND_UNUSED, mm_pkg::t_coord'($urandom),
                               mm_pkg::t_coord'($urandom), pick_value());
                else
                    load_random(($urandom_range(0, 1) == 0) ? mm_pkg::KIND_WRITE_A :
                                                              mm_pkg::KIND_WRITE_B);
            end
            // most bursts end in a compute; the rest are left as bare loads
            if ($urandom_range(0, 9) != 0) queue_compute();
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        dim_rows_a = mm_pkg::DIM_RESET;
        dim_cols_a = mm_pkg::DIM_RESET;
        dim_rows_b = mm_pkg::DIM_RESET;
        dim_cols_b = mm_pkg::DIM_RESET;
        a_loaded = '0;
        b_loaded = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 1x1 products at the element extremes; an unused kind must not disturb the store
        set_dims(4'd1, 4'd1, 4'd1, 4'd1);
        idle_mode = IDLE_BOTH;
        queue_word(mm_pkg::KIND_WRITE_A, 3'd0, 3'd0, 16'sh8000);
        queue_word(mm_pkg::KIND_WRITE_B, 3'd0, 3'd0, 16'sh8000);
        queue_compute();
        queue_word(mm_pkg::KIND_WRITE_A, 3'd0, 3'd0, 16'sh7FFF);
        queue_compute();
        queue_word(mm_pkg::KIND_WRITE_B, 3'd0, 3'd0, 16'sh7FFF);
        queue_word(KIND_UNUSED, 3'd0, 3'd0, 16'sh8000);
        queue_compute();
        drain();

        // zero and oversize dimension registers: 1 column of A against 8 rows of B
        set_dims(4'd0, 4'd0, 4'd15, 4'd3);
        queue_compute();
        queue_word(KIND_UNUSED, 3'd7, 3'd7, 16'sh7FFF);
        queue_compute();
        drain();

        // widest sum: eight products of the most negative element
        set_dims(4'd1, 4'd8, 4'd8, 4'd1);
        idle_mode = IDLE_NONE;
        for (int k = 0; k < 8; k++) begin
            queue_word(mm_pkg::KIND_WRITE_A, 3'd0, mm_pkg::t_coord'(k), 16'sh8000);
            queue_word(mm_pkg::KIND_WRITE_B, mm_pkg::t_coord'(k), 3'd0, 16'sh8000);
        end
        queue_compute();
        drain();

        run_random(4'd8,  4'd8, 4'd8,  4'd8,  IDLE_NONE, 75);
        run_random(4'd3,  4'd5, 4'd5,  4'd2,  IDLE_SEND, 45);
        run_random(4'd15, 4'd9, 4'd12, 4'd10, IDLE_RECV, 55);
        run_random(4'd2,  4'd8, 4'd8,  4'd1,  IDLE_BOTH, 40);
        run_random(4'd1,  4'd3, 4'd4,  4'd7,  IDLE_BOTH, 25);
        run_random(4'd7,  4'd1, 4'd1,  4'd8,  IDLE_SEND, 45);
        run_random(4'd5,  4'd6, 4'd6,  4'd4,  IDLE_RECV, 45);
        run_random(4'd4,  4'd0, 4'd0,  4'd0,  IDLE_NONE, 20);

        if (expected_products.size() != 0)
            report_error($sformatf("%0d elements of C never arrived", expected_products.size()));
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #TIMEOUT_NS;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
design/mm_pkg.sv
design/mm_in_if.sv
design/mm_out_if.sv
design/mm_cell.sv
design/mm_seq.sv
design/matrix_multiply_top.sv
bench/tb_matrix_multiply_top.sv
